>>> design/cssf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssf_pkg
// Shared types, constants and the status transition table of the connector
// status block.
// ----------------------------------------------------------------------------
package cssf_pkg;

  localparam int CONNECTORS = 8;
  localparam int ERRS       = 8;
  localparam int SLOTS      = CONNECTORS * ERRS;
  localparam int CONN_W     = $clog2(CONNECTORS);
  localparam int ERR_W      = $clog2(ERRS);
  localparam int SLOT_W     = $clog2(SLOTS);

  localparam logic [3:0] ST_AVAILABLE   = 4'd0;
  localparam logic [3:0] ST_UNAVAILABLE = 4'd7;
  localparam logic [3:0] ST_FAULTED     = 4'd8;
  localparam logic [3:0] NOTR           = 4'd15;

  localparam logic [4:0] EV_UNAVAIL = 5'd5;
  localparam logic [4:0] EV_AVAIL   = 5'd6;
  localparam logic [4:0] EV_I1      = 5'd9;
  localparam logic [4:0] EV_I8      = 5'd16;

  localparam logic [2:0] CIU_RESET  = 3'd1;
  localparam logic [3:0] INIT_RESET = 4'd0;

  localparam logic [1:0] REG_CIU   = 2'd0;
  localparam logic [1:0] REG_ZINIT = 2'd1;
  localparam logic [1:0] REG_OINIT = 2'd2;

  typedef enum logic [2:0] {
    ACT_EVENT    = 3'd0,
    ACT_RAISE    = 3'd1,
    ACT_CLEAR    = 3'd2,
    ACT_CLR_ALL  = 3'd3,
    ACT_TRIG     = 3'd4,
    ACT_TRIG_ALL = 3'd5,
    ACT_RESTART  = 3'd6,
    ACT_UNUSED   = 3'd7
  } action_t;

  typedef struct packed {
    logic [15:0] ident;
    logic [3:0]  code;
    logic        fault;
    logic [31:0] tstamp;
  } err_entry_t;

  localparam int ENTRY_W = $bits(err_entry_t);

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic apply;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic scan_done;
    logic rescan;
    logic more;
  } sts_t;

  localparam logic [3:0] TRANS [9][17] = '{
    '{4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, NOTR, NOTR, NOTR,
      NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR},
    '{NOTR, 4'd2, 4'd3, 4'd4, NOTR, NOTR, 4'd0, 4'd5, NOTR,
      NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR},
    '{NOTR, NOTR, 4'd3, 4'd4, NOTR, 4'd7, 4'd0, 4'd5, NOTR,
      NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR},
    '{NOTR, 4'd2, NOTR, 4'd4, NOTR, 4'd7, 4'd0, 4'd5, NOTR,
      NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR},
    '{NOTR, 4'd2, 4'd3, NOTR, NOTR, 4'd7, 4'd0, 4'd5, NOTR,
      NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR},
    '{4'd1, NOTR, NOTR, NOTR, NOTR, 4'd7, 4'd0, NOTR, NOTR,
      NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR},
    '{4'd1, NOTR, NOTR, NOTR, NOTR, 4'd7, 4'd0, NOTR, 4'd0,
      NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR},
    '{4'd1, 4'd2, 4'd3, 4'd4, NOTR, NOTR, 4'd0, NOTR, NOTR,
      NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR},
    '{NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR, NOTR,
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7}
  };

  // Connector zero only toggles Available/Unavailable and leaves Faulted.
  function automatic logic [3:0] next_state(logic is_zero, logic [3:0] st,
                                            logic [4:0] ev);
    logic [3:0] r;
    r = NOTR;
    if (ev <= EV_I8 && st <= ST_FAULTED) begin
      if (is_zero) begin
        if (st == ST_AVAILABLE && ev == EV_UNAVAIL) r = ST_UNAVAILABLE;
        else if (st == ST_UNAVAILABLE && ev == EV_AVAIL) r = ST_AVAILABLE;
        else if (st == ST_FAULTED && ev == EV_I1) r = ST_AVAILABLE;
        else if (st == ST_FAULTED && ev == EV_I8) r = ST_UNAVAILABLE;
      end else begin
        r = TRANS[st][ev];
      end
    end
    return r;
  endfunction

endpackage

>>> design/cssf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssf_if
// Request and result channels of the connector status block.
// ----------------------------------------------------------------------------
interface cssf_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  connector;
  logic [4:0]  event_code;
  logic [15:0] error_id;
  logic [3:0]  error_kind;
  logic        fault_flag;
  logic [31:0] time_now;

  modport source (output valid, action, connector, event_code, error_id,
                  error_kind, fault_flag, time_now, input ready);
  modport sink (input valid, action, connector, event_code, error_id,
                error_kind, fault_flag, time_now, output ready);
endinterface

interface cssf_res_if;
  logic        valid;
  logic        ready;
  logic        notify;
  logic [2:0]  report_connector;
  logic [3:0]  status;
  logic [3:0]  latest_code;
  logic [31:0] report_time;
  logic        accepted;
  logic        last;

  modport source (output valid, notify, report_connector, status, latest_code,
                  report_time, accepted, last, input ready);
  modport sink (input valid, notify, report_connector, status, latest_code,
                report_time, accepted, last, output ready);
endinterface

>>> design/cssf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cssf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/cssf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssf_ctrl
// Sequencer: capture a request, scan the error row, apply, present result.
// ----------------------------------------------------------------------------
module cssf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          res_valid,
  input  logic          res_ready,
  output cssf_pkg::cmd_t cmd,
  input  cssf_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_SCAN  = 5'b00100,
    S_APPLY = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (sts.direct) begin
          state_next = S_APPLY;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = sts.rescan ? S_START : S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) begin
          cmd.emit_done = 1'b1;
          state_next    = sts.more ? S_START : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/cssf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssf_dp
// Datapath: connector states, error store, row scan and result register.
// ----------------------------------------------------------------------------
module cssf_dp (
  input  logic          clk,
  input  logic          rst,
  input  cssf_pkg::cmd_t cmd,
  output cssf_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [3:0]    cfg_data,
  input  logic [2:0]    in_action,
  input  logic [2:0]    in_connector,
  input  logic [4:0]    in_event_code,
  input  logic [15:0]   in_error_id,
  input  logic [3:0]    in_error_kind,
  input  logic          in_fault_flag,
  input  logic [31:0]   in_time_now,
  output logic          o_notify,
  output logic [2:0]    o_conn,
  output logic [3:0]    o_status,
  output logic [3:0]    o_code,
  output logic [31:0]   o_time,
  output logic          o_acc,
  output logic          o_last
);

  localparam int CW = cssf_pkg::CONN_W;
  localparam int EW = cssf_pkg::ERR_W;

  // configuration
  logic [2:0] cin;
  logic [3:0] zinit, oinit;

  // captured request
  cssf_pkg::action_t act;
  logic [CW-1:0] item_conn;
  logic [4:0]    ev;
  logic [15:0]   eid;
  logic [3:0]    kind;
  logic          isf;
  logic [31:0]   now;

  logic [CW-1:0] cur;
  logic          pass2;
  logic [3:0]    conn_state [cssf_pkg::CONNECTORS];
  logic [cssf_pkg::SLOTS-1:0] err_valid;

  // scan
  logic          scan_act;
  logic [EW:0]   scan_cnt;
  logic          rd_pend;
  logic [EW-1:0] rd_slot;
  logic          any_fault, match_found, best_found;
  logic [EW-1:0] match_slot;
  logic [31:0]   best_time;
  logic [15:0]   best_id;
  logic [3:0]    best_code;

  cssf_pkg::err_entry_t q, wentry;
  logic                 ram_we;
  logic [cssf_pkg::SLOT_W-1:0] waddr;

  logic [2:0]    top;

  assign top = cin;

  // free slot: first clear valid bit in the row
  logic [cssf_pkg::ERRS-1:0] row;
  logic          free_found;
  logic [EW-1:0] free_slot;
  assign row = err_valid[{cur, {EW{1'b0}}} +: cssf_pkg::ERRS];

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int k = cssf_pkg::ERRS - 1; k >= 0; k--) begin
      if (!row[k]) begin
        free_found = 1'b1;
        free_slot  = EW'(k);
      end
    end
  end

  cssf_ram #(.WIDTH(cssf_pkg::ENTRY_W), .DEPTH(cssf_pkg::SLOTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr ({cur, scan_cnt[EW-1:0]}),
    .rdata (q)
  );

  // derived values for apply
  logic [3:0] cur_st, shown, nxt;
  logic       zok;
  assign cur_st = conn_state[cur];
  assign shown  = any_fault ? cssf_pkg::ST_FAULTED : cur_st;
  assign nxt    = cssf_pkg::next_state(cur == '0, cur_st, ev);
  assign zok    = (zinit == cssf_pkg::ST_AVAILABLE || zinit == cssf_pkg::ST_UNAVAILABLE
                   || zinit == cssf_pkg::ST_FAULTED) && (oinit <= cssf_pkg::ST_FAULTED);

  logic raise_ok;
  assign raise_ok = free_found && !match_found;

  assign sts.direct    = (act == cssf_pkg::ACT_UNUSED) ||
                         (act != cssf_pkg::ACT_TRIG_ALL && act != cssf_pkg::ACT_RESTART
                          && item_conn > top);
  assign sts.scan_done = !scan_act && !rd_pend;
  assign sts.rescan    = (act == cssf_pkg::ACT_CLEAR) && match_found && !pass2
                         && !sts.direct;
  assign sts.more      = (act == cssf_pkg::ACT_TRIG_ALL) && (cur != top);

  assign ram_we = cmd.apply && !sts.direct && act == cssf_pkg::ACT_RAISE && raise_ok;
  assign waddr  = {cur, free_slot};
  always_comb begin
    wentry        = '0;
    wentry.ident  = eid;
    wentry.code   = kind;
    wentry.fault  = isf;
    wentry.tstamp = now;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cin       <= cssf_pkg::CIU_RESET;
      zinit     <= cssf_pkg::INIT_RESET;
      oinit     <= cssf_pkg::INIT_RESET;
      err_valid <= '0;
      scan_act  <= 1'b0;
      rd_pend   <= 1'b0;
      pass2     <= 1'b0;
      for (int i = 0; i < cssf_pkg::CONNECTORS; i++) conn_state[i] <= cssf_pkg::INIT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cssf_pkg::REG_CIU:   cin   <= cfg_data[2:0];
          cssf_pkg::REG_ZINIT: zinit <= cfg_data;
          cssf_pkg::REG_OINIT: oinit <= cfg_data;
          default: ;
        endcase
      end
      // walk the row, one read per cycle
      if (cmd.scan_start) begin
        scan_act <= 1'b1;
        scan_cnt <= '0;
      end else if (scan_act) begin
        scan_cnt <= scan_cnt + 1'b1;
        if (scan_cnt == (EW+1)'(cssf_pkg::ERRS - 1)) scan_act <= 1'b0;
      end
      rd_pend <= scan_act && !cmd.scan_start;
      rd_slot <= scan_cnt[EW-1:0];

      if (cmd.apply && !sts.direct) begin
        case (act)
          cssf_pkg::ACT_EVENT: begin
            if (nxt != cssf_pkg::NOTR) conn_state[cur] <= nxt;
          end
          cssf_pkg::ACT_RAISE: begin
            if (raise_ok) err_valid[{cur, free_slot}] <= 1'b1;
          end
          cssf_pkg::ACT_CLEAR: begin
            if (pass2) begin
              pass2 <= 1'b0;
            end else if (match_found) begin
              err_valid[{cur, match_slot}] <= 1'b0;
              pass2 <= 1'b1;
            end
          end
          cssf_pkg::ACT_CLR_ALL: begin
            err_valid[{cur, {EW{1'b0}}} +: cssf_pkg::ERRS] <= '0;
          end
          cssf_pkg::ACT_RESTART: begin
            if (zok) begin
              err_valid <= '0;
              for (int i = 0; i < cssf_pkg::CONNECTORS; i++)
                conn_state[i] <= (i == 0) ? zinit : oinit;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // request capture, scan accumulation and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act       <= cssf_pkg::action_t'(in_action);
      item_conn <= in_connector;
      ev        <= in_event_code;
      eid       <= in_error_id;
      kind      <= in_error_kind;
      isf       <= in_fault_flag;
      now       <= in_time_now;
      cur       <= (in_action == cssf_pkg::ACT_TRIG_ALL ||
                    in_action == cssf_pkg::ACT_RESTART) ? '0 : in_connector;
    end else if (cmd.emit_done && sts.more) begin
      cur <= cur + 1'b1;
    end

    if (cmd.scan_start) begin
      any_fault   <= 1'b0;
      match_found <= 1'b0;
      best_found  <= 1'b0;
    end else if (rd_pend && err_valid[{cur, rd_slot}]) begin
      if (q.fault) any_fault <= 1'b1;
      if (q.ident == eid) begin
        match_found <= 1'b1;
        match_slot  <= rd_slot;
      end
      if (!best_found || q.tstamp > best_time ||
          (q.tstamp == best_time && q.ident < best_id)) begin
        best_found <= 1'b1;
        best_time  <= q.tstamp;
        best_id    <= q.ident;
        best_code  <= q.code;
      end
    end

    if (cmd.apply) begin
      o_conn   <= cur;
      o_time   <= now;
      o_code   <= '0;
      o_notify <= 1'b0;
      o_acc    <= 1'b0;
      o_status <= shown;
      o_last   <= !sts.more;
      if (sts.direct) begin
        o_conn   <= item_conn;
        o_status <= cssf_pkg::ST_UNAVAILABLE;
        o_time   <= '0;
        o_last   <= 1'b1;
      end else begin
        case (act)
          cssf_pkg::ACT_EVENT: begin
            if (nxt != cssf_pkg::NOTR) begin
              o_acc    <= 1'b1;
              o_notify <= !any_fault;
              o_status <= any_fault ? cssf_pkg::ST_FAULTED : nxt;
              o_code   <= best_found ? best_code : 4'd0;
            end
          end
          cssf_pkg::ACT_RAISE: begin
            if (raise_ok) begin
              o_acc    <= 1'b1;
              o_notify <= 1'b1;
              o_status <= (any_fault || isf) ? cssf_pkg::ST_FAULTED : cur_st;
              o_code   <= kind;
            end
          end
          cssf_pkg::ACT_CLEAR: begin
            if (pass2) begin
              o_acc    <= 1'b1;
              o_notify <= !any_fault;
              o_code   <= best_found ? best_code : 4'd0;
            end
          end
          cssf_pkg::ACT_CLR_ALL: begin
            o_acc    <= 1'b1;
            o_notify <= 1'b1;
            o_status <= cur_st;
          end
          cssf_pkg::ACT_TRIG, cssf_pkg::ACT_TRIG_ALL: begin
            o_acc    <= 1'b1;
            o_notify <= 1'b1;
            o_code   <= best_found ? best_code : 4'd0;
            o_time   <= best_found ? best_time : now;
          end
          cssf_pkg::ACT_RESTART: begin
            o_acc    <= zok;
            o_status <= zok ? zinit : shown;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

>>> design/connector_status_fsm_with_faults_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connector_status_fsm_with_faults_unit
// Charging status and active error table per connector.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (valid/ready): an event, raise/clear of an
//   error, clear all, a status trigger, trigger all, or restart.
//   result carries the answers (valid/ready); last marks the final answer
//   of a request. Trigger all gives one answer per connector in use.
//   cfg_we/cfg_index/cfg_data write the three registers; write them only
//   while no request is outstanding.
// Timing:
//   One request at a time, taken only while the block is idle. A request
//   passes a decode step, a walk through the eight error slots of its
//   connector (eight RAM reads, one per cycle, then the registered data
//   is taken in) and an apply step before its answer is valid. A clear
//   that hits an entry walks the row a second time. Trigger all walks
//   the row of each further connector once the previous answer is taken.
//   An unused connector or action code skips the walk. The block returns
//   to idle after the last answer before the next request is accepted.
// Reset clears all error valid bits, loads the reset register values and
// puts every connector in Available. While the receiver stalls, hold the
// result and accept no further request.
// ----------------------------------------------------------------------------
module connector_status_fsm_with_faults_unit (
  input  logic        clk,
  input  logic        rst,
  cssf_req_if.sink    req,
  cssf_res_if.source  result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  cssf_pkg::cmd_t cmd;
  cssf_pkg::sts_t sts;

  // sequencer: drives the handshakes and steps the datapath
  cssf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: state, error store and the result register
  cssf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_action     (req.action),
    .in_connector  (req.connector),
    .in_event_code (req.event_code),
    .in_error_id   (req.error_id),
    .in_error_kind (req.error_kind),
    .in_fault_flag (req.fault_flag),
    .in_time_now   (req.time_now),
    .o_notify      (result.notify),
    .o_conn        (result.report_connector),
    .o_status      (result.status),
    .o_code        (result.latest_code),
    .o_time        (result.report_time),
    .o_acc         (result.accepted),
    .o_last        (result.last)
  );

endmodule

>>> tb/sv/tb_connector_status_fsm_with_faults_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_connector_status_fsm_with_faults_unit
// Self-checking bench for the connector status block: a directed table of
// requests followed by random request streams, every result compared against
// a behavioural predictor of status, error tables and reports.
// ----------------------------------------------------------------------------
module tb_connector_status_fsm_with_faults_unit;

  localparam int WATCHDOG    = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = cssf_pkg::REG_CIU;
  logic [3:0] cfg_data = '0;

  always #1 clk = ~clk;

  cssf_req_if req ();
  cssf_res_if result ();

  connector_status_fsm_with_faults_unit dut (
    .clk(clk), .rst(rst), .req(req.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  connector;
    logic [4:0]  event_code;
    logic [15:0] error_id;
    logic [3:0]  error_kind;
    logic        fault_flag;
    logic [31:0] time_now;
  } request_t;

  typedef struct packed {
    logic        notify;
    logic [2:0]  report_connector;
    logic [3:0]  status;
    logic [3:0]  latest_code;
    logic [31:0] report_time;
    logic        accepted;
    logic        last;
  } report_t;

  // Predictor state: own copy of registers, statuses and error tables.
  logic [2:0]  p_ciu;
  logic [3:0]  p_zinit, p_oinit;
  logic [3:0]  p_state [cssf_pkg::CONNECTORS];
  logic        p_valid [cssf_pkg::SLOTS];
  logic [15:0] p_ident [cssf_pkg::SLOTS];
  logic [3:0]  p_code  [cssf_pkg::SLOTS];
  logic        p_fault [cssf_pkg::SLOTS];
  logic [31:0] p_time  [cssf_pkg::SLOTS];

  report_t expected_reports [$];
  report_t last_got = '0;
  int  errors = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_request = 1'b0;
  bit  hold_taken = 1'b0;
  bit  timed_out = 1'b0;

  function automatic logic conn_faulted(int c);
    for (int k = 0; k < cssf_pkg::ERRS; k++)
      if (p_valid[c*cssf_pkg::ERRS+k] && p_fault[c*cssf_pkg::ERRS+k]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [3:0] shown(int c);
    return conn_faulted(c) ? cssf_pkg::ST_FAULTED : p_state[c];
  endfunction

  function automatic int newest_slot(int c);
    int best;
    best = -1;
    for (int k = 0; k < cssf_pkg::ERRS; k++) begin
      int s;
      s = c*cssf_pkg::ERRS + k;
      if (p_valid[s] && (best < 0 || p_time[s] > p_time[best] ||
          (p_time[s] == p_time[best] && p_ident[s] < p_ident[best])))
        best = s;
    end
    return best;
  endfunction

  function automatic int slot_of(int c, logic [15:0] id);
    for (int k = 0; k < cssf_pkg::ERRS; k++)
      if (p_valid[c*cssf_pkg::ERRS+k] && p_ident[c*cssf_pkg::ERRS+k] == id)
        return c*cssf_pkg::ERRS + k;
    return -1;
  endfunction

  function automatic logic [3:0] step_status(int c, logic [3:0] st, logic [4:0] ev);
    if (ev > cssf_pkg::EV_I8 || st > cssf_pkg::ST_FAULTED) return cssf_pkg::NOTR;
    if (c == 0) begin
      if (st == cssf_pkg::ST_AVAILABLE && ev == cssf_pkg::EV_UNAVAIL)
        return cssf_pkg::ST_UNAVAILABLE;
      if (st == cssf_pkg::ST_UNAVAILABLE && ev == cssf_pkg::EV_AVAIL)
        return cssf_pkg::ST_AVAILABLE;
      if (st == cssf_pkg::ST_FAULTED && ev == cssf_pkg::EV_I1)
        return cssf_pkg::ST_AVAILABLE;
      if (st == cssf_pkg::ST_FAULTED && ev == cssf_pkg::EV_I8)
        return cssf_pkg::ST_UNAVAILABLE;
      return cssf_pkg::NOTR;
    end
    return cssf_pkg::TRANS[st][ev];
  endfunction

  function automatic report_t make_report(logic n, int c, logic [3:0] st,
                                          logic [3:0] cd, logic [31:0] t, logic a);
    report_t r;
    r = '{notify: n, report_connector: c[2:0], status: st, latest_code: cd,
          report_time: t, accepted: a, last: 1'b0};
    return r;
  endfunction

  function automatic report_t status_report(int c, logic [31:0] now);
    int ls;
    ls = newest_slot(c);
    return make_report(1'b1, c, shown(c), ls < 0 ? 4'd0 : p_code[ls],
                       ls < 0 ? now : p_time[ls], 1'b1);
  endfunction

  // Advance the predictor by one request and queue the reports it causes.
  task automatic predict_request(request_t q);
    report_t rs [$];
    int c, top, ls, s, free;
    logic [3:0] d;
    c = int'(q.connector);
    top = int'(p_ciu);
    if (q.action == cssf_pkg::ACT_RESTART) begin
      logic ok;
      ok = (p_zinit == cssf_pkg::ST_AVAILABLE || p_zinit == cssf_pkg::ST_UNAVAILABLE ||
            p_zinit == cssf_pkg::ST_FAULTED) && p_oinit <= cssf_pkg::ST_FAULTED;
      if (ok) begin
        for (int k = 0; k < cssf_pkg::CONNECTORS; k++)
          p_state[k] = (k == 0) ? p_zinit : p_oinit;
        for (int k = 0; k < cssf_pkg::SLOTS; k++) p_valid[k] = 1'b0;
      end
      rs.push_back(make_report(1'b0, 0, shown(0), 4'd0, q.time_now, ok));
    end else if (q.action == cssf_pkg::ACT_TRIG_ALL) begin
      for (int k = 0; k <= top; k++) rs.push_back(status_report(k, q.time_now));
    end else if (q.action == cssf_pkg::ACT_UNUSED || c > top) begin
      rs.push_back(make_report(1'b0, c, cssf_pkg::ST_UNAVAILABLE, 4'd0, 32'd0, 1'b0));
    end else if (q.action == cssf_pkg::ACT_EVENT) begin
      d = step_status(c, p_state[c], q.event_code);
      if (d == cssf_pkg::NOTR) begin
        rs.push_back(make_report(1'b0, c, shown(c), 4'd0, q.time_now, 1'b0));
      end else begin
        p_state[c] = d;
        ls = newest_slot(c);
        rs.push_back(make_report(!conn_faulted(c), c, shown(c),
                                 ls < 0 ? 4'd0 : p_code[ls], q.time_now, 1'b1));
      end
    end else if (q.action == cssf_pkg::ACT_RAISE) begin
      free = -1;
      for (int k = cssf_pkg::ERRS - 1; k >= 0; k--)
        if (!p_valid[c*cssf_pkg::ERRS+k]) free = c*cssf_pkg::ERRS + k;
      if (slot_of(c, q.error_id) >= 0 || free < 0) begin
        rs.push_back(make_report(1'b0, c, shown(c), 4'd0, q.time_now, 1'b0));
      end else begin
        p_valid[free] = 1'b1;
        p_ident[free] = q.error_id;
        p_code[free] = q.error_kind;
        p_fault[free] = q.fault_flag;
        p_time[free] = q.time_now;
        rs.push_back(make_report(1'b1, c, shown(c), q.error_kind, q.time_now, 1'b1));
      end
    end else if (q.action == cssf_pkg::ACT_CLEAR) begin
      s = slot_of(c, q.error_id);
      if (s < 0) begin
        rs.push_back(make_report(1'b0, c, shown(c), 4'd0, q.time_now, 1'b0));
      end else begin
        p_valid[s] = 1'b0;
        ls = newest_slot(c);
        rs.push_back(make_report(!conn_faulted(c), c, shown(c),
                                 ls < 0 ? 4'd0 : p_code[ls], q.time_now, 1'b1));
      end
    end else if (q.action == cssf_pkg::ACT_CLR_ALL) begin
      for (int k = 0; k < cssf_pkg::ERRS; k++) p_valid[c*cssf_pkg::ERRS+k] = 1'b0;
      rs.push_back(make_report(1'b1, c, p_state[c], 4'd0, q.time_now, 1'b1));
    end else begin
      rs.push_back(status_report(c, q.time_now));
    end
    rs[rs.size()-1].last = 1'b1;
    foreach (rs[i]) expected_reports.push_back(rs[i]);
  endtask

  // Request driver state
  request_t pending [$];
  int       gap_left = 0;

  initial begin
    req.valid = 1'b0;
    req.action = cssf_pkg::ACT_EVENT;
    req.connector = '0;
    req.event_code = '0;
    req.error_id = '0;
    req.error_kind = '0;
    req.fault_flag = 1'b0;
    req.time_now = '0;
    result.ready = 1'b0;
  end

  // Drive requests: offer the head of the pending list, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      logic fired;
      fired = req.valid && req.ready;
      if (fired) begin
        predict_request(pending.pop_front());
      end
      if ((fired || !req.valid) && gap_left > 0) begin
        gap_left <= gap_left - 1;
        req.valid <= 1'b0;
      end else if ((fired || !req.valid) && pending.size() > 0) begin
        if (!no_idle && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(1, 9);
          req.valid <= 1'b0;
        end else begin
          req.valid <= 1'b1;
          {req.action, req.connector, req.event_code, req.error_id, req.error_kind,
           req.fault_flag, req.time_now} <= pending[0];
        end
      end else if (fired) begin
        req.valid <= 1'b0;
      end
    end
  end

  // Receive and compare results; stall in random bursts or a long hold-off.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) begin
        report_t got, want;
        got = '{result.notify, result.report_connector, result.status,
                result.latest_code, result.report_time, result.accepted, result.last};
        last_got = got;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      if (hold_request && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        result.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 6) == 0) begin
        stall_left <= $urandom_range(0, 8);
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles in which nothing is accepted.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (result.valid && result.ready) || rst ||
        (pending.size() == 0 && expected_reports.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("[connector_status_fsm_with_faults_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cssf_pkg::REG_CIU) p_ciu = val[2:0];
    else if (idx == cssf_pkg::REG_ZINIT) p_zinit = val;
    else if (idx == cssf_pkg::REG_OINIT) p_oinit = val;
  endtask

  // Wait for every request and result, then let the block go quiet.
  task automatic drain();
    while (pending.size() > 0 || expected_reports.size() > 0 || req.valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic request_t mk(cssf_pkg::action_t a, int c, int ev, int id, int kind,
                                  bit f, logic [31:0] t);
    request_t q;
    q = '{a, c[2:0], ev[4:0], id[15:0], kind[3:0], f, t};
    return q;
  endfunction

  // Random request: mostly well-formed on connectors in use, small id pool.
  function automatic request_t random_request();
    request_t q;
    int r;
    r = $urandom_range(0, 99);
    q.connector = (r < 90) ? 3'($urandom_range(0, p_ciu)) : 3'($urandom_range(0, 7));
    q.event_code = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 16));
    q.error_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
    q.error_kind = 4'($urandom);
    q.fault_flag = ($urandom_range(0, 3) == 0);
    q.time_now = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(100, 108);
    r = $urandom_range(0, 99);
    if (r < 35) q.action = cssf_pkg::ACT_EVENT;
    else if (r < 60) q.action = cssf_pkg::ACT_RAISE;
    else if (r < 78) q.action = cssf_pkg::ACT_CLEAR;
    else if (r < 83) q.action = cssf_pkg::ACT_CLR_ALL;
    else if (r < 91) q.action = cssf_pkg::ACT_TRIG;
    else if (r < 96) q.action = cssf_pkg::ACT_TRIG_ALL;
    else if (r < 98) q.action = cssf_pkg::ACT_RESTART;
    else q.action = cssf_pkg::ACT_UNUSED;
    return q;
  endfunction

  // Directed table: a known answer for the obvious rows, predictor elsewhere.
  typedef struct {
    request_t req_row;
    bit       typed;
    report_t  answer;
  } row_t;

  row_t directed [$];

  initial begin
    p_ciu = cssf_pkg::CIU_RESET;
    p_zinit = cssf_pkg::INIT_RESET;
    p_oinit = cssf_pkg::INIT_RESET;
    for (int k = 0; k < cssf_pkg::CONNECTORS; k++) p_state[k] = cssf_pkg::ST_AVAILABLE;
    for (int k = 0; k < cssf_pkg::SLOTS; k++) begin
      p_valid[k] = 1'b0; p_ident[k] = '0; p_code[k] = '0; p_fault[k] = 1'b0; p_time[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Trigger after reset: Available, no error, time echoed.
    directed.push_back('{mk(cssf_pkg::ACT_TRIG, 1, 0, 0, 0, 0, 32'hFFFF_FFFF), 1,
                         '{1'b1, 3'd1, cssf_pkg::ST_AVAILABLE, 4'd0, 32'hFFFF_FFFF,
                           1'b1, 1'b1}});
    // Connector beyond those in use.
    directed.push_back('{mk(cssf_pkg::ACT_EVENT, 7, 0, 0, 0, 0, 32'd5), 1,
                         '{1'b0, 3'd7, cssf_pkg::ST_UNAVAILABLE, 4'd0, 32'd0,
                           1'b0, 1'b1}});
    // Unused action code.
    directed.push_back('{mk(cssf_pkg::ACT_UNUSED, 3, 31, 16'hFFFF, 15, 1, 32'd9), 1,
                         '{1'b0, 3'd3, cssf_pkg::ST_UNAVAILABLE, 4'd0, 32'd0,
                           1'b0, 1'b1}});
    // Unknown event code.
    directed.push_back('{mk(cssf_pkg::ACT_EVENT, 1, 31, 0, 0, 0, 32'd1), 1,
                         '{1'b0, 3'd1, cssf_pkg::ST_AVAILABLE, 4'd0, 32'd1,
                           1'b0, 1'b1}});
    directed.push_back('{mk(cssf_pkg::ACT_EVENT, 1, 0, 0, 0, 0, 32'd2), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_EVENT, 1, 1, 0, 0, 0, 32'd3), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_RAISE, 1, 0, 16'hFFFF, 15, 1, 32'd10), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_RAISE, 1, 0, 16'hFFFF, 3, 0, 32'd11), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_RAISE, 1, 0, 16'h0000, 4, 0, 32'd10), 0, '0});
    // Event while faulted: transition without a notification.
    directed.push_back('{mk(cssf_pkg::ACT_EVENT, 1, 2, 0, 0, 0, 32'd12), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_TRIG, 1, 0, 0, 0, 0, 32'd13), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_CLEAR, 1, 0, 16'h1234, 0, 0, 32'd14), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_CLEAR, 1, 0, 16'h0000, 0, 0, 32'd15), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_CLEAR, 1, 0, 16'hFFFF, 0, 0, 32'd16), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_EVENT, 0, 5, 0, 0, 0, 32'd17), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_EVENT, 0, 0, 0, 0, 0, 32'd18), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_EVENT, 0, 6, 0, 0, 0, 32'd19), 0, '0});
    for (int k = 0; k < 9; k++)
      directed.push_back('{mk(cssf_pkg::ACT_RAISE, 0, 0, k, k + 1, k == 2, 32'd20), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_EVENT, 0, 9, 0, 0, 0, 32'd21), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_TRIG_ALL, 0, 0, 0, 0, 0, 32'd22), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_CLR_ALL, 0, 0, 0, 0, 0, 32'd23), 0, '0});
    directed.push_back('{mk(cssf_pkg::ACT_RESTART, 0, 0, 0, 0, 0, 32'd24), 0, '0});

    // Walk the table; typed rows give a single answer, checked here as well.
    foreach (directed[i]) begin
      pending.push_back(directed[i].req_row);
      drain();
      if (directed[i].typed && last_got !== directed[i].answer) begin
        $display("%0t: mismatch on directed row %0d expected %p actual %p",
                 $time, i, directed[i].answer, last_got);
        errors++;
      end
    end

    // Phases over several register settings, the extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      logic [3:0] z, o;
      case (phase)
        0: begin z = cssf_pkg::ST_AVAILABLE;   o = cssf_pkg::ST_AVAILABLE; end
        1: begin z = cssf_pkg::ST_UNAVAILABLE; o = cssf_pkg::ST_FAULTED;   end
        2: begin z = cssf_pkg::ST_FAULTED;     o = 4'd3;                   end
        3: begin z = 4'd15;                    o = 4'd6;                   end
        4: begin z = 4'd0;                     o = 4'd15;                  end
        default: begin z = cssf_pkg::ST_AVAILABLE; o = 4'd1; end
      endcase
      write_reg(cssf_pkg::REG_CIU,
                (phase == 0) ? 4'd7 : (phase == 1) ? 4'd0 : 4'($urandom_range(1, 7)));
      write_reg(cssf_pkg::REG_ZINIT, z);
      write_reg(cssf_pkg::REG_OINIT, o);
      pending.push_back(mk(cssf_pkg::ACT_RESTART, 0, 0, 0, 0, 0, 32'd0));
      if (phase == 2) begin
        // Long receiver hold-off while requests keep coming.
        hold_request = 1'b1;
        for (int k = 0; k < 20; k++) pending.push_back(random_request());
        wait (hold_taken && hold_left == 0);
      end
      if (phase == 5) no_idle = 1'b1;
      for (int k = 0; k < 70; k++) pending.push_back(random_request());
      drain();
    end

    if (errors == 0) begin
      $display("[connector_status_fsm_with_faults_unit] OK");
    end else begin
      $display("[connector_status_fsm_with_faults_unit] ERROR");
    end
    $finish;
  end

endmodule
